// ----- rtl/sda_pkg.sv -----
package sda_pkg;

  // width of the binary working values (covers 16 digits plus headroom)
  localparam int VAL_W = 56;
  // iteration counter width
  localparam int CNT_W = 6;
  // field widths
  localparam int MAG_W = 60;
  localparam int BCD_W = 64;
  localparam int MAX_DIGITS = 15;

  // operation codes
  localparam logic [1:0] FN_ADD = 2'd0;
  localparam logic [1:0] FN_SUB = 2'd1;
  localparam logic [1:0] FN_MUL = 2'd2;
  localparam logic [1:0] FN_DIV = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic             load;
    logic             conv;
    logic             prep;
    logic             iter;
    logic             check;
    logic             dabble;
    logic             finish;
    logic [CNT_W-1:0] idx;
  } sda_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_addsub;
  } sda_stat_t;

  // ten to the power n, used at elaboration
  function automatic logic [63:0] pow10(input int n);
    logic [63:0] v;
    v = 64'd1;
    for (int i = 0; i < 16; i++) begin
      if (i < n) begin
        v = v * 64'd10;
      end
    end
    return v;
  endfunction

  // double dabble correction: add three to every digit of five or more
  function automatic logic [BCD_W-1:0] dabble_adj(input logic [BCD_W-1:0] d);
    logic [BCD_W-1:0] r;
    r = d;
    for (int i = 0; i < BCD_W / 4; i++) begin
      if (d[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = d[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/sda_ctrl.sv -----
module sda_ctrl #(
  parameter int DIGITS = sda_pkg::MAX_DIGITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  sda_pkg::sda_stat_t  stat,
  output sda_pkg::sda_cmd_t   cmd
);

  localparam int ND = (DIGITS > sda_pkg::MAX_DIGITS) ? sda_pkg::MAX_DIGITS : DIGITS;
  localparam logic [sda_pkg::CNT_W-1:0] CONV_LAST = sda_pkg::CNT_W'(ND - 1);
  localparam logic [sda_pkg::CNT_W-1:0] BIT_LAST = sda_pkg::CNT_W'(sda_pkg::VAL_W - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_ITER = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_DABB = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]                state_r, state_nxt;
  logic [sda_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      accept;
  logic                      fin_go;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign fin_go     = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  // command decode
  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.conv   = (state_r == ST_CONV);
    cmd.prep   = (state_r == ST_PREP);
    cmd.iter   = (state_r == ST_ITER);
    cmd.check  = (state_r == ST_CHK);
    cmd.dabble = (state_r == ST_DABB);
    cmd.finish = fin_go;
    cmd.idx    = cnt_r;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CONV;
          cnt_nxt   = CONV_LAST;
        end
      end
      ST_CONV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_PREP;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_PREP: begin
        cnt_nxt = BIT_LAST;
        if (stat.is_addsub) begin
          state_nxt = ST_DABB;
        end else begin
          state_nxt = ST_ITER;
        end
      end
      ST_ITER: begin
        if (cnt_r == '0) begin
          state_nxt = ST_CHK;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_CHK: begin
        state_nxt = ST_DABB;
        cnt_nxt   = BIT_LAST;
      end
      ST_DABB: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks
  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_CONV) && (cnt_r == CONV_LAST))
    else $error("accepted beat did not start conversion");
  a_conv_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> (cnt_r <= CONV_LAST))
    else $error("digit index out of range");
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_tready))
    else $error("result overwrote a waiting beat");
  a_valid_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r && (state_r == ST_IDLE))
    else $error("finished result not presented");

endmodule

// ----- rtl/sda_dp.sv -----
module sda_dp #(
  parameter int DIGITS = sda_pkg::MAX_DIGITS
) (
  input  logic                          clk,
  input  sda_pkg::sda_cmd_t             cmd,
  output sda_pkg::sda_stat_t            stat,
  input  logic [1:0]                    func,
  input  logic [sda_pkg::MAG_W-1:0]     first_magnitude,
  input  logic                          first_negative,
  input  logic [sda_pkg::MAG_W-1:0]     second_magnitude,
  input  logic                          second_negative,
  output logic [sda_pkg::MAG_W-1:0]     result_magnitude,
  output logic                          result_negative,
  output logic [sda_pkg::MAG_W-1:0]     remainder_magnitude,
  output logic                          remainder_negative,
  output logic                          status
);

  localparam int VW = sda_pkg::VAL_W;
  localparam logic [63:0] LIM64 = sda_pkg::pow10(DIGITS);
  localparam logic [VW-1:0] LIM = LIM64[VW-1:0];

  logic [1:0]                  func_r;
  logic                        an_r, bn_r;
  logic [sda_pkg::MAG_W-1:0]   abcd_r, bbcd_r;
  logic [VW-1:0]               a_r, b_r, acc_r, rem_r;
  logic                        fail_r, rneg_r, remneg_r;
  logic [sda_pkg::BCD_W-1:0]   dq_r, dr_r;
  logic [sda_pkg::MAG_W-1:0]   res_mag_r, rem_mag_r;
  logic                        res_neg_r, rem_neg_r, status_r;

  logic [3:0]    dig;
  logic [3:0]    adig, bdig;
  logic          bs;
  logic [VW-1:0] sum, diff_ab, diff_ba;
  logic [VW-1:0] mul_t;
  logic [VW-1:0] rem_sh;
  logic          bitsel;
  logic [sda_pkg::BCD_W-1:0] dq_adj, dr_adj;

  assign stat.is_addsub = (func_r == sda_pkg::FN_ADD) || (func_r == sda_pkg::FN_SUB);

  // per-step arithmetic
  always_comb begin
    dig     = cmd.idx[3:0];
    adig    = abcd_r[4*dig +: 4];
    bdig    = bbcd_r[4*dig +: 4];
    bs      = bn_r ^ (func_r == sda_pkg::FN_SUB);
    sum     = a_r + b_r;
    diff_ab = a_r - b_r;
    diff_ba = b_r - a_r;
    bitsel  = (func_r == sda_pkg::FN_MUL) ? b_r[cmd.idx] : a_r[cmd.idx];
    mul_t   = {acc_r[VW-2:0], 1'b0} + (bitsel ? a_r : '0);
    rem_sh  = {rem_r[VW-2:0], bitsel};
    dq_adj  = sda_pkg::dabble_adj(dq_r);
    dr_adj  = sda_pkg::dabble_adj(dr_r);
  end

  always_ff @(posedge clk) begin
    // capture the accepted beat
    if (cmd.load) begin
      func_r   <= func;
      an_r     <= first_negative;
      bn_r     <= second_negative;
      abcd_r   <= first_magnitude;
      bbcd_r   <= second_magnitude;
      a_r      <= '0;
      b_r      <= '0;
      acc_r    <= '0;
      rem_r    <= '0;
      fail_r   <= 1'b0;
      rneg_r   <= 1'b0;
      remneg_r <= 1'b0;
      dq_r     <= '0;
      dr_r     <= '0;
    end
    // decimal to binary, most significant digit first
    if (cmd.conv) begin
      a_r <= {a_r[VW-4:0], 3'b000} + {a_r[VW-2:0], 1'b0} + VW'(adig);
      b_r <= {b_r[VW-4:0], 3'b000} + {b_r[VW-2:0], 1'b0} + VW'(bdig);
    end
    // signs, the divide-by-zero check, and the whole add or subtract
    if (cmd.prep) begin
      unique case (func_r)
        sda_pkg::FN_ADD, sda_pkg::FN_SUB: begin
          if (an_r == bs) begin
            acc_r  <= sum;
            rneg_r <= an_r && (sum != '0);
            fail_r <= (sum >= LIM);
          end else if (a_r >= b_r) begin
            acc_r  <= diff_ab;
            rneg_r <= an_r && (diff_ab != '0);
            fail_r <= (diff_ab >= LIM);
          end else begin
            acc_r  <= diff_ba;
            rneg_r <= bs;
            fail_r <= (diff_ba >= LIM);
          end
        end
        sda_pkg::FN_MUL: begin
          rneg_r <= an_r ^ bn_r;
        end
        default: begin
          rneg_r   <= an_r ^ bn_r;
          remneg_r <= an_r;
          fail_r   <= (b_r == '0);
        end
      endcase
    end
    // shift-add multiply or restoring divide, one bit per cycle
    if (cmd.iter) begin
      if (func_r == sda_pkg::FN_MUL) begin
        if (!fail_r) begin
          acc_r <= mul_t;
          if (mul_t >= LIM) begin
            fail_r <= 1'b1;
          end
        end
      end else begin
        if (rem_sh >= b_r) begin
          rem_r <= rem_sh - b_r;
          acc_r <= {acc_r[VW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          acc_r <= {acc_r[VW-2:0], 1'b0};
        end
      end
    end
    // range check of quotient and remainder
    if (cmd.check && (func_r == sda_pkg::FN_DIV)) begin
      if ((acc_r >= LIM) || (rem_r >= LIM)) begin
        fail_r <= 1'b1;
      end
    end
    // binary to decimal, most significant bit first
    if (cmd.dabble) begin
      dq_r <= {dq_adj[sda_pkg::BCD_W-2:0], acc_r[cmd.idx]};
      dr_r <= {dr_adj[sda_pkg::BCD_W-2:0], rem_r[cmd.idx]};
    end
    // output register
    if (cmd.finish) begin
      res_mag_r <= fail_r ? '0 : dq_r[sda_pkg::MAG_W-1:0];
      res_neg_r <= fail_r ? 1'b0 : rneg_r;
      rem_mag_r <= fail_r ? '0 : dr_r[sda_pkg::MAG_W-1:0];
      rem_neg_r <= fail_r ? 1'b0 : remneg_r;
      status_r  <= fail_r;
    end
  end

  assign result_magnitude    = res_mag_r;
  assign result_negative     = res_neg_r;
  assign remainder_magnitude = rem_mag_r;
  assign remainder_negative  = rem_neg_r;
  assign status              = status_r;

endmodule

// ----- rtl/signed_decimal_alu.sv -----
// Signed decimal ALU: add, subtract, multiply, divide with remainder on two
// sign-magnitude operands of DIGITS packed BCD digits.
// Input channel in_*: one beat per operation, accepted when in_tvalid and
// in_tready are high at a rising edge. in_tready is high only while the
// block is idle, so one operation is in flight at a time.
// Result channel out_*: one beat per operation, held in an output register
// until taken; the block returns to idle as soon as the result is loaded,
// so the next operation runs while a result waits for the receiver.
// An operation runs the digit-serial decimal-to-binary conversion, then for
// multiply and divide the one-bit-per-cycle shift-add multiplier or restoring
// divider over 56 bits, then the 56-step binary-to-BCD conversion. If the
// receiver stalls, a finished operation waits before the output register
// until it is free. Reset (rst_n low, synchronous) returns the controller
// to idle and drops out_tvalid.
module signed_decimal_alu #(
  parameter int DIGITS = sda_pkg::MAX_DIGITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // func[1:0], first_magnitude[61:2], first_negative[62],
  // second_magnitude[122:63], second_negative[123], zero fill above
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_magnitude[59:0], result_negative[60], remainder_magnitude[120:61],
  // remainder_negative[121], status[122], zero fill above
  output logic [127:0] out_tdata
);

  sda_pkg::sda_cmd_t  cmd;
  sda_pkg::sda_stat_t stat;
  logic [sda_pkg::MAG_W-1:0] res_mag, rem_mag;
  logic res_neg, rem_neg, status;

  sda_ctrl #(.DIGITS(DIGITS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sda_dp #(.DIGITS(DIGITS)) u_dp (
    .clk                 (clk),
    .cmd                 (cmd),
    .stat                (stat),
    .func                (in_tdata[1:0]),
    .first_magnitude     (in_tdata[61:2]),
    .first_negative      (in_tdata[62]),
    .second_magnitude    (in_tdata[122:63]),
    .second_negative     (in_tdata[123]),
    .result_magnitude    (res_mag),
    .result_negative     (res_neg),
    .remainder_magnitude (rem_mag),
    .remainder_negative  (rem_neg),
    .status              (status)
  );

  // pack the result beat
  assign out_tdata = {5'b00000, status, rem_neg, rem_mag, res_neg, res_mag};

endmodule

// ----- tb/testbench.sv -----
module testbench;

  localparam int NDIG = 15;
  localparam int NRAND = 730;

  typedef struct packed {
    logic [1:0]  func;
    logic [59:0] a_mag;
    logic        a_neg;
    logic [59:0] b_mag;
    logic        b_neg;
  } alu_op_t;

  typedef struct packed {
    logic [59:0] res_mag;
    logic        res_neg;
    logic [59:0] rem_mag;
    logic        rem_neg;
    logic        status;
  } alu_res_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;

  alu_op_t  pending_ops[$];
  alu_res_t expected_results[$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       ops_sent = 0;
  int       send_gap = 0;
  int       recv_gap = 0;
  bit       hold_sender = 0;
  bit       stimulus_done = 0;
  int       op_count[4];

  signed_decimal_alu #(.DIGITS(NDIG)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // nibbles taken at their binary value times decimal weight
  function automatic logic [63:0] bcd_to_bin(input logic [59:0] bcd);
    logic [63:0] v;
    v = 64'd0;
    for (int i = NDIG - 1; i >= 0; i--) begin
      v = v * 64'd10 + 64'(bcd[4*i +: 4]);
    end
    return v;
  endfunction

  function automatic logic [59:0] bin_to_bcd(input logic [63:0] v);
    logic [59:0] r;
    r = '0;
    for (int i = 0; i < NDIG; i++) begin
      r[4*i +: 4] = 4'(v % 64'd10);
      v = v / 64'd10;
    end
    return r;
  endfunction

  // expected outcome of one operation
  function automatic alu_res_t alu_predict(input alu_op_t op);
    logic [63:0] a, b, lim, res, rem;
    logic        rneg, remneg, fail, bs;
    alu_res_t    r;
    a = bcd_to_bin(op.a_mag);
    b = bcd_to_bin(op.b_mag);
    lim = 64'd1;
    for (int i = 0; i < NDIG; i++) lim = lim * 64'd10;
    res = '0; rem = '0; rneg = 0; remneg = 0; fail = 0;
    case (op.func)
      sda_pkg::FN_ADD, sda_pkg::FN_SUB: begin
        bs = op.b_neg ^ (op.func == sda_pkg::FN_SUB);
        if (op.a_neg == bs) begin
          res = a + b; rneg = op.a_neg;
        end else if (a >= b) begin
          res = a - b; rneg = op.a_neg;
        end else begin
          res = b - a; rneg = bs;
        end
        if (res == 0) rneg = 0;
        if (res >= lim) fail = 1;
      end
      sda_pkg::FN_MUL: begin
        if (a != 0 && b > (lim - 1) / a) fail = 1;
        else begin
          res = a * b; rneg = op.a_neg ^ op.b_neg;
        end
      end
      default: begin
        if (b == 0) fail = 1;
        else begin
          res = a / b; rem = a % b;
          rneg = op.a_neg ^ op.b_neg; remneg = op.a_neg;
          if (res >= lim || rem >= lim) fail = 1;
        end
      end
    endcase
    r = '0;
    if (fail) r.status = 1'b1;
    else begin
      r.res_mag = bin_to_bcd(res); r.res_neg = rneg;
      r.rem_mag = bin_to_bcd(rem); r.rem_neg = remneg;
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch on %s at result %0d: got %h want %h", what, results_seen, got, want);
    mismatches++;
  endtask

  function automatic logic [59:0] rand_digits(input int n, input bit wild);
    logic [59:0] v;
    v = '0;
    for (int i = 0; i < n; i++) begin
      v[4*i +: 4] = wild ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 9));
    end
    return v;
  endfunction

  function automatic alu_op_t make_op(input logic [1:0] f, input logic [59:0] a, input logic an,
                                      input logic [59:0] b, input logic bn);
    alu_op_t op;
    op.func = f; op.a_mag = a; op.a_neg = an; op.b_mag = b; op.b_neg = bn;
    return op;
  endfunction

  // stimulus
  initial begin
    logic [59:0] nines;
    alu_op_t     op;
    int          la, lb;
    nines = '0;
    for (int i = 0; i < NDIG; i++) nines[4*i +: 4] = 4'd9;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // directed corners
    pending_ops.push_back(make_op(sda_pkg::FN_ADD, '0, 1'b1, '0, 1'b1));
    pending_ops.push_back(make_op(sda_pkg::FN_ADD, nines, 1'b0, 60'h1, 1'b0));
    pending_ops.push_back(make_op(sda_pkg::FN_ADD, nines, 1'b1, nines, 1'b0));
    pending_ops.push_back(make_op(sda_pkg::FN_SUB, 60'h5, 1'b1, 60'h5, 1'b1));
    pending_ops.push_back(make_op(sda_pkg::FN_SUB, 60'h3, 1'b0, 60'h7, 1'b0));
    pending_ops.push_back(make_op(sda_pkg::FN_SUB, nines, 1'b1, nines, 1'b0));
    pending_ops.push_back(make_op(sda_pkg::FN_MUL, '0, 1'b1, nines, 1'b0));
    pending_ops.push_back(make_op(sda_pkg::FN_MUL, nines, 1'b1, 60'h1, 1'b1));
    pending_ops.push_back(make_op(sda_pkg::FN_MUL, nines, 1'b0, 60'h2, 1'b0));
    pending_ops.push_back(make_op(sda_pkg::FN_MUL, 60'h999999, 1'b1, 60'h999999, 1'b0));
    pending_ops.push_back(make_op(sda_pkg::FN_DIV, nines, 1'b1, '0, 1'b0));
    pending_ops.push_back(make_op(sda_pkg::FN_DIV, '0, 1'b1, 60'h7, 1'b0));
    pending_ops.push_back(make_op(sda_pkg::FN_DIV, 60'h100, 1'b1, 60'h7, 1'b1));
    pending_ops.push_back(make_op(sda_pkg::FN_DIV, nines, 1'b0, 60'h1, 1'b1));
    pending_ops.push_back(make_op(sda_pkg::FN_DIV, 60'h5, 1'b0, nines, 1'b0));
    pending_ops.push_back(make_op(sda_pkg::FN_DIV, {60{1'b1}}, 1'b1, 60'h1, 1'b0));
    pending_ops.push_back(make_op(sda_pkg::FN_ADD, {60{1'b1}}, 1'b0, {60{1'b1}}, 1'b1));
    pending_ops.push_back(make_op(sda_pkg::FN_MUL, 60'hF, 1'b0, 60'hF, 1'b1));
    // let the directed part drain before the random part
    wait (pending_ops.size() == 0);
    hold_sender = 1'b1;
    wait (expected_results.size() == 0 && !in_tvalid);
    hold_sender = 1'b0;
    for (int n = 0; n < NRAND; n++) begin
      la = $urandom_range(0, NDIG);
      lb = $urandom_range(0, 7) == 0 ? NDIG : $urandom_range(0, NDIG);
      op.func = 2'($urandom_range(0, 3));
      op.a_mag = rand_digits(la, $urandom_range(0, 9) == 0);
      op.b_mag = rand_digits(lb, $urandom_range(0, 9) == 0);
      if ($urandom_range(0, 19) == 0) op.b_mag = '0;
      op.a_neg = 1'($urandom);
      op.b_neg = 1'($urandom);
      pending_ops.push_back(op);
    end
    stimulus_done = 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      send_gap  <= $urandom_range(0, 13);
    end else if (in_tvalid && !in_tready) begin
      // hold the beat
    end else if (send_gap > 0) begin
      in_tvalid <= 1'b0;
      send_gap  <= send_gap - 1;
    end else if (pending_ops.size() > 0 && !hold_sender) begin
      alu_op_t op;
      op = pending_ops.pop_front();
      expected_results.push_back(alu_predict(op));
      op_count[op.func]++;
      ops_sent++;
      in_tvalid <= 1'b1;
      in_tdata  <= {4'b0, op.b_neg, op.b_mag, op.a_neg, op.a_mag, op.func};
      send_gap  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap   <= $urandom_range(0, 13);
    end else begin
      if (out_tvalid && out_tready) begin
        alu_res_t got, want;
        got.res_mag = out_tdata[59:0];
        got.res_neg = out_tdata[60];
        got.rem_mag = out_tdata[120:61];
        got.rem_neg = out_tdata[121];
        got.status  = out_tdata[122];
        results_seen++;
        if (expected_results.size() == 0) begin
          report("unexpected beat", 64'(results_seen), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.res_mag !== want.res_mag) report("result magnitude", got.res_mag, want.res_mag);
          if (got.res_neg !== want.res_neg) report("result sign", got.res_neg, want.res_neg);
          if (got.rem_mag !== want.rem_mag) report("remainder magnitude", got.rem_mag, want.rem_mag);
          if (got.rem_neg !== want.rem_neg) report("remainder sign", got.rem_neg, want.rem_neg);
          if (got.status !== want.status) report("status", got.status, want.status);
        end
        if (out_tdata[127:123] !== '0) report("zero fill", 64'(out_tdata[127:123]), 64'd0);
      end
      // stall pattern per beat, with stretches of none
      if (out_tvalid && out_tready) begin
        recv_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap   <= recv_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // end of run
  initial begin
    wait (stimulus_done && pending_ops.size() == 0 && !in_tvalid);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);
    $display("%0d operations sent (add %0d, sub %0d, mul %0d, div %0d), %0d results checked",
             ops_sent, op_count[0], op_count[1], op_count[2], op_count[3], results_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #12000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sda_pkg.sv
rtl/sda_ctrl.sv
rtl/sda_dp.sv
rtl/signed_decimal_alu.sv
tb/testbench.sv
